// ----- sv/hsv_pkg.sv -----
package hsv_pkg;

  // Fixed field widths.
  localparam int HUE_W = 16;
  localparam int CH_W  = 8;

  // Hue reduction constants.
  localparam int HUE_RANGE   = 360;
  localparam int SECTOR_SPAN = 60;
  // floor(2^16 / 360); the quotient estimate is low by at most one.
  localparam int RECIP       = 182;
  localparam int RECIP_SHIFT = 16;
  localparam int QUOT_W      = 8;
  localparam int DEG_W       = 9;
  localparam int OFFSET_W    = 6;
  localparam int SECTOR_W    = 3;
  localparam int LEVEL_SHIFT = 8;
  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

  // Sector codes, named after the hue band they cover.
  localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [SECTOR_W-1:0] SEC_MAGENTA_RED   = 3'd5;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness_value;
  } hsv_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } hsv_out_t;

  // Sector and in-sector position handed from hue reduction to level math.
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [CH_W-1:0]     pos;
    logic [CH_W-1:0]     sat;
    logic [CH_W-1:0]     val;
  } hsv_sec_t;

  // Levels handed to the channel selection stage.
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                grey;
    logic [CH_W-1:0]     val;
    logic [CH_W-1:0]     p;
    logic [CH_W-1:0]     q;
    logic [CH_W-1:0]     t;
  } hsv_lvl_t;

  // (v * (255 - k)) >> 8
  function automatic logic [CH_W-1:0] level_from(input logic [CH_W-1:0] v,
                                                 input logic [CH_W-1:0] k);
    logic [2*CH_W-1:0] prod;
    prod = v * (FULL_SCALE - k);
    return prod[2*CH_W-1:LEVEL_SHIFT];
  endfunction

endpackage

// ----- sv/hsv_hue_reduce.sv -----
module hsv_hue_reduce
  import hsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_stall,
  input  hsv_in_t  up_data,
  output logic     dn_valid,
  input  logic     dn_stall,
  output hsv_sec_t dn_data
);

  localparam int PROD_W = HUE_W + QUOT_W;
  localparam int DIFF_W = HUE_W + 1;

  // Stage 1 registers: quotient estimate.
  logic              s1_valid_r;
  logic [HUE_W-1:0]  s1_hue_r;
  logic [QUOT_W-1:0] s1_quot_r;
  logic [CH_W-1:0]   s1_sat_r, s1_val_r;
  // Stage 2 registers: hue reduced modulo 360.
  logic              s2_valid_r;
  logic [DEG_W-1:0]  s2_deg_r;
  logic [CH_W-1:0]   s2_sat_r, s2_val_r;
  // Stage 3 registers: sector and position.
  logic              s3_valid_r;
  hsv_sec_t          s3_data_r;

  logic s1_en, s2_en, s3_en;
  logic [PROD_W-1:0]   recip_prod;
  logic [DIFF_W-1:0]   rem_full;
  logic [DEG_W:0]      rem_est;
  logic [DEG_W-1:0]    deg_nxt;
  logic [SECTOR_W-1:0] sector_nxt;
  logic [DEG_W-1:0]    base;
  logic [DEG_W-1:0]    offset_full;
  logic [OFFSET_W-1:0] offset;
  logic [CH_W+1:0]     pos_scaled;

  // A stage loads when it is empty or its contents move on.
  assign s3_en    = !(s3_valid_r && dn_stall);
  assign s2_en    = !(s2_valid_r && !s3_en);
  assign s1_en    = !(s1_valid_r && !s2_en);
  assign up_stall = !s1_en;

  // Quotient estimate by reciprocal multiply.
  assign recip_prod = up_data.hue * PROD_W'(RECIP);

  // Remainder estimate lies below twice the range; one correction step.
  assign rem_full = {1'b0, s1_hue_r} - DIFF_W'(s1_quot_r * DIFF_W'(HUE_RANGE));
  assign rem_est  = rem_full[DEG_W:0];
  always_comb begin
    if (rem_est >= (DEG_W+1)'(HUE_RANGE)) begin
      deg_nxt = DEG_W'(rem_est - (DEG_W+1)'(HUE_RANGE));
    end else begin
      deg_nxt = rem_est[DEG_W-1:0];
    end
  end

  // Sector by comparison against the band edges.
  always_comb begin
    if (s2_deg_r >= DEG_W'(5*SECTOR_SPAN)) begin
      sector_nxt = SEC_MAGENTA_RED;
    end else if (s2_deg_r >= DEG_W'(4*SECTOR_SPAN)) begin
      sector_nxt = SEC_BLUE_MAGENTA;
    end else if (s2_deg_r >= DEG_W'(3*SECTOR_SPAN)) begin
      sector_nxt = SEC_CYAN_BLUE;
    end else if (s2_deg_r >= DEG_W'(2*SECTOR_SPAN)) begin
      sector_nxt = SEC_GREEN_CYAN;
    end else if (s2_deg_r >= DEG_W'(SECTOR_SPAN)) begin
      sector_nxt = SEC_YELLOW_GREEN;
    end else begin
      sector_nxt = SEC_RED_YELLOW;
    end
  end

  // Offset within the sector, scaled by 17/4 to span 0..250.
  always_comb begin
    case (sector_nxt)
      SEC_RED_YELLOW:   base = DEG_W'(0);
      SEC_YELLOW_GREEN: base = DEG_W'(SECTOR_SPAN);
      SEC_GREEN_CYAN:   base = DEG_W'(2*SECTOR_SPAN);
      SEC_CYAN_BLUE:    base = DEG_W'(3*SECTOR_SPAN);
      SEC_BLUE_MAGENTA: base = DEG_W'(4*SECTOR_SPAN);
      default:          base = DEG_W'(5*SECTOR_SPAN);
    endcase
  end
  assign offset_full = s2_deg_r - base;
  assign offset      = offset_full[OFFSET_W-1:0];
  assign pos_scaled  = {offset, 4'b0000} + (CH_W+2)'(offset);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= up_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
      if (s3_en) s3_valid_r <= s2_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_hue_r  <= up_data.hue;
      s1_quot_r <= recip_prod[PROD_W-1:RECIP_SHIFT];
      s1_sat_r  <= up_data.saturation;
      s1_val_r  <= up_data.brightness_value;
    end
    if (s2_en) begin
      s2_deg_r <= deg_nxt;
      s2_sat_r <= s1_sat_r;
      s2_val_r <= s1_val_r;
    end
    if (s3_en) begin
      s3_data_r.sector <= sector_nxt;
      s3_data_r.pos    <= pos_scaled[CH_W+1:2];
      s3_data_r.sat    <= s2_sat_r;
      s3_data_r.val    <= s2_val_r;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_data  = s3_data_r;

endmodule

// ----- sv/hsv_levels.sv -----
module hsv_levels
  import hsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_stall,
  input  hsv_sec_t up_data,
  output logic     dn_valid,
  input  logic     dn_stall,
  output hsv_lvl_t dn_data
);

  // Stage 4 registers: scaled saturations and p.
  logic                s4_valid_r;
  logic [SECTOR_W-1:0] s4_sector_r;
  logic                s4_grey_r;
  logic [CH_W-1:0]     s4_val_r, s4_p_r, s4_kq_r, s4_kt_r;
  // Stage 5 registers: all three levels.
  logic                s5_valid_r;
  hsv_lvl_t            s5_data_r;

  logic s4_en, s5_en;
  logic [2*CH_W-1:0] kq_prod, kt_prod;

  assign s5_en    = !(s5_valid_r && dn_stall);
  assign s4_en    = !(s4_valid_r && !s5_en);
  assign up_stall = !s4_en;

  // s * pos and s * (255 - pos), both shifted right by 8.
  assign kq_prod = up_data.sat * up_data.pos;
  assign kt_prod = up_data.sat * (FULL_SCALE - up_data.pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s4_en) s4_valid_r <= up_valid;
      if (s5_en) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_sector_r <= up_data.sector;
      s4_grey_r   <= (up_data.sat == '0);
      s4_val_r    <= up_data.val;
      s4_p_r      <= level_from(up_data.val, up_data.sat);
      s4_kq_r     <= kq_prod[2*CH_W-1:LEVEL_SHIFT];
      s4_kt_r     <= kt_prod[2*CH_W-1:LEVEL_SHIFT];
    end
    if (s5_en) begin
      s5_data_r.sector <= s4_sector_r;
      s5_data_r.grey   <= s4_grey_r;
      s5_data_r.val    <= s4_val_r;
      s5_data_r.p      <= s4_p_r;
      s5_data_r.q      <= level_from(s4_val_r, s4_kq_r);
      s5_data_r.t      <= level_from(s4_val_r, s4_kt_r);
    end
  end

  assign dn_valid = s5_valid_r;
  assign dn_data  = s5_data_r;

endmodule

// ----- sv/hsv_channel_sel.sv -----
module hsv_channel_sel
  import hsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_stall,
  input  hsv_lvl_t up_data,
  output logic     dn_valid,
  input  logic     dn_stall,
  output hsv_out_t dn_data
);

  logic     out_valid_r;
  hsv_out_t out_data_r;
  hsv_out_t rgb_nxt;
  logic     en;

  assign en       = !(out_valid_r && dn_stall);
  assign up_stall = !en;

  // Channel order by sector; grey input bypasses the levels.
  always_comb begin
    if (up_data.grey) begin
      rgb_nxt = '{red: up_data.val, green: up_data.val, blue: up_data.val};
    end else begin
      case (up_data.sector)
        SEC_RED_YELLOW: begin
          rgb_nxt = '{red: up_data.val, green: up_data.t, blue: up_data.p};
        end
        SEC_YELLOW_GREEN: begin
          rgb_nxt = '{red: up_data.q, green: up_data.val, blue: up_data.p};
        end
        SEC_GREEN_CYAN: begin
          rgb_nxt = '{red: up_data.p, green: up_data.val, blue: up_data.t};
        end
        SEC_CYAN_BLUE: begin
          rgb_nxt = '{red: up_data.p, green: up_data.q, blue: up_data.val};
        end
        SEC_BLUE_MAGENTA: begin
          rgb_nxt = '{red: up_data.t, green: up_data.p, blue: up_data.val};
        end
        default: begin
          rgb_nxt = '{red: up_data.val, green: up_data.p, blue: up_data.q};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= rgb_nxt;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_data  = out_data_r;

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, one pixel per clock while out_stall is low. The hue may be
// any 16-bit value and is reduced modulo 360; saturation and value are 8 bits, and
// zero saturation gives grey at the value level. The block is a six-stage pipeline
// (hue reduction by reciprocal multiply, modulo correction, sector split, scaled
// saturations, level multiplies and channel selection), and while out_stall is low a
// new beat is taken in every cycle. Each stage holds its beat while the stage after it
// is full and stalled, so empty stages still fill while the output waits.
module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hsv_out_t out_data
);

  logic     sec_valid, sec_stall;
  hsv_sec_t sec_data;
  logic     lvl_valid, lvl_stall;
  hsv_lvl_t lvl_data;

  // Hue to sector and in-sector position.
  hsv_hue_reduce u_hue_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (sec_valid),
    .dn_stall (sec_stall),
    .dn_data  (sec_data)
  );

  // The p, q and t levels.
  hsv_levels u_levels (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sec_valid),
    .up_stall (sec_stall),
    .up_data  (sec_data),
    .dn_valid (lvl_valid),
    .dn_stall (lvl_stall),
    .dn_data  (lvl_data)
  );

  // Channel order and output register.
  hsv_channel_sel u_channel_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lvl_valid),
    .up_stall (lvl_stall),
    .up_data  (lvl_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

endmodule

// ----- dv/hsv_to_rgb_converter_tb.sv -----
module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_DIRECTED = 21;

  // One directed pixel; the expected color is typed in only where it is obvious.
  typedef struct {
    hsv_in_t  pix;
    bit       typed;
    hsv_out_t rgb;
  } pixel_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hsv_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hsv_out_t out_data;

  hsv_out_t rgb_pending[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       tx_bursty = 0;
  bit       rx_bursty = 0;
  bit       hold_req = 0;

  pixel_row_t directed_rows [NUM_DIRECTED] = '{
    // Grey pixels and black pixels.
    '{'{16'd0,     8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd65535, 8'd0,   8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{16'd200,   8'd0,   8'd77},  1'b1, '{8'd77,  8'd77,  8'd77}},
    '{'{16'd0,     8'd255, 8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    // Pure primaries at the start of their sectors, with wrapped hues.
    '{'{16'd0,     8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd120,   8'd255, 8'd255}, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{'{16'd240,   8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{16'd360,   8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd65520, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    // Every sector, sector edges and hues far above one turn.
    '{'{16'd59,    8'd255, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd60,    8'd200, 8'd180}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd179,   8'd255, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd180,   8'd128, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd300,   8'd255, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd359,   8'd1,   8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd65519, 8'd255, 8'd128}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd65535, 8'd255, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd270,   8'd1,   8'd1},   1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd30,    8'd128, 8'd64},  1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'd719,   8'd255, 8'd200}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{16'h8000,  8'haa,  8'h55},  1'b0, '{8'd0, 8'd0, 8'd0}}
  };

  hsv_to_rgb_converter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // (v * (255 - k)) >> 8, truncated.
  function automatic logic [CH_W-1:0] scaled_level(input int unsigned v, input int unsigned k);
    int unsigned prod;
    prod = v * (int'(FULL_SCALE) - k);
    return CH_W'(prod >> LEVEL_SHIFT);
  endfunction

  // Expected color of one pixel.
  function automatic hsv_out_t predict_rgb(input hsv_in_t px);
    int unsigned         deg;
    int unsigned         offset;
    int unsigned         pos;
    int unsigned         sat;
    logic [SECTOR_W-1:0] sector;
    logic [CH_W-1:0]     v;
    logic [CH_W-1:0]     p;
    logic [CH_W-1:0]     q;
    logic [CH_W-1:0]     t;
    hsv_out_t            rgb;
    v   = px.brightness_value;
    sat = px.saturation;
    if (sat == 0) begin
      rgb = '{v, v, v};
    end else begin
      deg    = px.hue % HUE_RANGE;
      sector = SECTOR_W'(deg / SECTOR_SPAN);
      offset = deg - sector * SECTOR_SPAN;
      // Position within the sector spans 0 to 250.
      pos    = (offset * 17) >> 2;
      p      = scaled_level(v, sat);
      q      = scaled_level(v, (sat * pos) >> LEVEL_SHIFT);
      t      = scaled_level(v, (sat * (int'(FULL_SCALE) - pos)) >> LEVEL_SHIFT);
      case (sector)
        SEC_RED_YELLOW:   rgb = '{v, t, p};
        SEC_YELLOW_GREEN: rgb = '{q, v, p};
        SEC_GREEN_CYAN:   rgb = '{p, v, t};
        SEC_CYAN_BLUE:    rgb = '{p, q, v};
        SEC_BLUE_MAGENTA: rgb = '{t, p, v};
        default:          rgb = '{v, p, q};
      endcase
    end
    return rgb;
  endfunction

  // Random pixel, weighted toward grey, sector edges and extreme levels.
  function automatic hsv_in_t random_pixel();
    hsv_in_t px;
    int      kind;
    kind = $urandom_range(0, 9);
    px.hue              = HUE_W'($urandom_range(0, HUE_RANGE - 1));
    px.saturation       = CH_W'($urandom_range(0, 255));
    px.brightness_value = CH_W'($urandom_range(0, 255));
    case (kind)
      0, 1: px.hue = HUE_W'($urandom_range(0, 65535));
      2: px.saturation = 8'd0;
      3: px.hue = HUE_W'($urandom_range(0, 5) * SECTOR_SPAN + ($urandom_range(0, 1) ? 59 : 0)
                         + $urandom_range(0, 180) * HUE_RANGE);
      4: begin
        px.saturation       = CH_W'($urandom_range(0, 1) ? 8'd255 - $urandom_range(0, 1)
                                                         : $urandom_range(0, 1));
        px.brightness_value = CH_W'($urandom_range(0, 1) ? 8'd255 - $urandom_range(0, 1)
                                                         : $urandom_range(0, 1));
      end
      default: ;
    endcase
    return px;
  endfunction

  // Offer one pixel beat and record its expected color once it is taken.
  task automatic send_pixel(input hsv_in_t px, input bit typed, input hsv_out_t rgb);
    if (tx_bursty && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    rgb_pending.push_back(typed ? rgb : predict_rgb(px));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (rgb_pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, or one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 0;
      end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest pending color.
  always @(posedge clk) begin : check_results
    hsv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_pending.size() == 0) begin
        $error("result beat %h arrived with no pixel pending", out_data);
        fail_count++;
      end else begin
        want = rgb_pending.pop_front();
        if (out_data.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_data.red);
          fail_count++;
        end
        if (out_data.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_data.green);
          fail_count++;
        end
        if (out_data.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: directed table, back-pressure fill, random pixels, then a quiet tail.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_bursty = 1;
    rx_bursty = 1;
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].rgb);

    // Hold the output off while pixels keep coming, so the pipeline backs up.
    tx_bursty = 0;
    rx_bursty = 0;
    hold_req  = 1;
    repeat (30) send_pixel(random_pixel(), 1'b0, '0);
    in_valid <= 1'b0;
    wait_for_results();
    @(negedge clk);

    tx_bursty = 1;
    rx_bursty = 1;
    repeat (290) send_pixel(random_pixel(), 1'b0, '0);

    // Full rate on both sides for the last stretch.
    tx_bursty = 0;
    rx_bursty = 0;
    repeat (60) send_pixel(random_pixel(), 1'b0, '0);
    in_valid <= 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- hsv_to_rgb_converter.f -----
sv/hsv_pkg.sv
sv/hsv_hue_reduce.sv
sv/hsv_levels.sv
sv/hsv_channel_sel.sv
sv/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_tb.sv
